FILE: hw/rtl/context_offset_calculator_core_assert.svh
// ----------------------------------------------------------------------------
// context_offset_calculator_core_assert.svh
// Assertion macros for the context offset calculator; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CONTEXT_OFFSET_CALCULATOR_CORE_ASSERT_SVH
`define CONTEXT_OFFSET_CALCULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the block clock, quiet in reset.
`define COC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("coc assertion failed");
// Next-cycle implication, sampled on the block clock, quiet in reset.
`define COC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("coc assertion failed");
`else
`define COC_ASSERT_NOW(lbl, ante, cons)
`define COC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/coc_pkg.sv
// ----------------------------------------------------------------------------
// coc_pkg
// Shared constants, codes and the decoded item type of the offset calculator.
// ----------------------------------------------------------------------------
package coc_pkg;

    // Width of the running offset and the saturation limit
    localparam int OFFSET_BITS = 32;
    localparam int LEN_W       = 32;
    localparam int OUT_OFF_W   = 32;
    localparam int SUM_W       = ((OFFSET_BITS > LEN_W + 1) ? OFFSET_BITS : LEN_W + 1) + 1;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    localparam int NUM_FRAMES = 6;
    localparam int FRAME_W    = 3;
    localparam int QUOT_W     = LEN_W - 1;

    // Divide by three: floor(n / 3) = (n * MAGIC) >> 33 for 32-bit n
    localparam logic [LEN_W-1:0] DIV3_MAGIC = 32'hAAAA_AAAB;
    localparam int               DIV3_SHIFT = 33;

    // Program modes
    localparam logic [2:0] MODE_NUCL    = 3'd0;
    localparam logic [2:0] MODE_PROT    = 3'd1;
    localparam logic [2:0] MODE_TRQUERY = 3'd2;
    localparam logic [2:0] MODE_TRSUBJ  = 3'd3;
    localparam logic [2:0] MODE_TRBOTH  = 3'd4;

    // Strand codes
    localparam logic [1:0] STRAND_UNKNOWN = 2'd0;
    localparam logic [1:0] STRAND_PLUS    = 2'd1;
    localparam logic [1:0] STRAND_MINUS   = 2'd2;
    localparam logic [1:0] STRAND_BOTH    = 2'd3;

    // First-context values for a minus first query
    localparam logic [1:0] FCTX_NONE     = 2'd0;
    localparam logic [1:0] FCTX_NA_MINUS = 2'd1;
    localparam logic [1:0] FCTX_TR_MINUS = 2'd3;

    // Configuration register indexes
    localparam logic CFG_PROGRAM_MODE  = 1'b0;
    localparam logic CFG_STRAND_OPTION = 1'b1;

    // One query, decoded and ready for the frame sequencer
    typedef struct packed {
        logic [LEN_W-1:0]      len;
        logic [QUOT_W-1:0]     quot;      // len / 3
        logic [1:0]            rem;       // len % 3
        logic                  translate;
        logic                  first;
        logic [1:0]            fctx;
        logic                  bad;
        logic [NUM_FRAMES-1:0] incl;      // frames that add to the offset
        logic [FRAME_W-1:0]    last_idx;
    } t_item;

endpackage

FILE: hw/rtl/coc_decode.sv
// ----------------------------------------------------------------------------
// coc_decode
// Resolves strand and mode of one query, flags bad input and splits the
// length by three for the translated frames.
// ----------------------------------------------------------------------------
module coc_decode (
    input  logic [2:0]                  i_program_mode,
    input  logic [1:0]                  i_strand_option,
    input  logic [coc_pkg::LEN_W-1:0]   i_query_length,
    input  logic [2:0]                  i_query_strand,
    input  logic                        i_first_query,
    output coc_pkg::t_item              o_item
);

    logic                                is_na;
    logic                                is_tr;
    logic                                use_strand;
    logic [2:0]                          strand;
    logic [2*coc_pkg::LEN_W-1:0]         prod;
    logic [coc_pkg::QUOT_W-1:0]          quot;
    logic [coc_pkg::LEN_W-1:0]           three_q;
    logic [coc_pkg::NUM_FRAMES-1:0]      frame_mask;
    logic [coc_pkg::NUM_FRAMES-1:0]      plus_mask;
    logic [coc_pkg::NUM_FRAMES-1:0]      strand_mask;

    assign is_na      = (i_program_mode == coc_pkg::MODE_NUCL);
    assign is_tr      = (i_program_mode == coc_pkg::MODE_TRQUERY) ||
                        (i_program_mode == coc_pkg::MODE_TRBOTH);
    assign use_strand = is_na || is_tr;

    always_comb begin
        strand = i_query_strand;
        if (use_strand && ((i_strand_option == coc_pkg::STRAND_PLUS) ||
                           (i_strand_option == coc_pkg::STRAND_MINUS))) begin
            strand = {1'b0, i_strand_option};
        end
    end

    // Reciprocal multiply for len / 3, remainder from the low bits only
    assign prod    = (2*coc_pkg::LEN_W)'(i_query_length) *
                     (2*coc_pkg::LEN_W)'(coc_pkg::DIV3_MAGIC);
    assign quot    = prod[2*coc_pkg::LEN_W-1:coc_pkg::DIV3_SHIFT];
    assign three_q = {1'b0, quot} + {quot, 1'b0};

    always_comb begin
        if (is_tr) begin
            frame_mask = 6'b111111;
            plus_mask  = 6'b000111;
        end else if (is_na) begin
            frame_mask = 6'b000011;
            plus_mask  = 6'b000001;
        end else begin
            frame_mask = 6'b000001;
            plus_mask  = 6'b000001;
        end
        if (use_strand && (strand == {1'b0, coc_pkg::STRAND_PLUS})) begin
            strand_mask = plus_mask;
        end else if (use_strand && (strand == {1'b0, coc_pkg::STRAND_MINUS})) begin
            strand_mask = ~plus_mask;
        end else begin
            strand_mask = '1;
        end
    end

    always_comb begin
        o_item.len       = i_query_length;
        o_item.quot      = quot;
        o_item.rem       = i_query_length[1:0] - three_q[1:0];
        o_item.translate = is_tr;
        o_item.first     = i_first_query;
        o_item.bad       = (i_program_mode > coc_pkg::MODE_TRBOTH) ||
                           (use_strand && (strand > {1'b0, coc_pkg::STRAND_BOTH}));
        o_item.incl      = frame_mask & strand_mask;
        o_item.fctx      = coc_pkg::FCTX_NONE;
        if (use_strand && (strand == {1'b0, coc_pkg::STRAND_MINUS})) begin
            o_item.fctx = is_tr ? coc_pkg::FCTX_TR_MINUS : coc_pkg::FCTX_NA_MINUS;
        end
        if (o_item.bad) begin
            o_item.last_idx = '0;
        end else if (is_tr) begin
            o_item.last_idx = coc_pkg::FRAME_W'(coc_pkg::NUM_FRAMES - 1);
        end else if (is_na) begin
            o_item.last_idx = coc_pkg::FRAME_W'(1);
        end else begin
            o_item.last_idx = '0;
        end
    end

endmodule

FILE: hw/rtl/coc_frame.sv
// ----------------------------------------------------------------------------
// coc_frame
// Frame sequencer: holds one decoded query, steps through its frames one per
// cycle while not stalled, accumulates the running offset with saturation and
// drives the result register.
// ----------------------------------------------------------------------------
module coc_frame (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_item_valid,
    input  coc_pkg::t_item                  i_item,
    output logic                            o_item_ready,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [coc_pkg::FRAME_W-1:0]     o_frame_index,
    output logic [coc_pkg::OUT_OFF_W-1:0]   o_context_offset,
    output logic [1:0]                      o_first_context,
    output logic                            o_overflow,
    output logic                            o_bad_input,
    output logic                            o_last
);

    logic                                r_item_valid;
    coc_pkg::t_item                      r_item;
    logic [coc_pkg::FRAME_W-1:0]         r_frame;
    logic [coc_pkg::OFFSET_BITS-1:0]     r_run;
    logic [1:0]                          r_fctx;

    logic                                out_ready;
    logic                                emit;
    logic                                is_last;
    logic                                restart;
    logic [1:0]                          shift;
    logic [coc_pkg::QUOT_W-1:0]          adj;
    logic [coc_pkg::SUM_W-1:0]           add;
    logic [coc_pkg::SUM_W-1:0]           base;
    logic [coc_pkg::SUM_W-1:0]           sum;
    logic                                sat;
    logic [coc_pkg::OFFSET_BITS-1:0]     n_run;
    logic [coc_pkg::SUM_W-1:0]           shown;

    assign out_ready    = !o_out_valid || !i_out_stall;
    assign emit         = r_item_valid && out_ready;
    assign is_last      = (r_frame == r_item.last_idx);
    assign o_item_ready = !r_item_valid || (emit && is_last);
    assign restart      = (r_frame == '0) && r_item.first;

    // Frame i of a translated query reads the length shifted by i mod 3
    always_comb begin
        case (r_frame) inside
            3'd1, 3'd4: shift = 2'd1;
            3'd2, 3'd5: shift = 2'd2;
            default:    shift = 2'd0;
        endcase
        if ((r_item.rem >= shift) || (r_item.quot == '0)) begin
            adj = r_item.quot;
        end else begin
            adj = r_item.quot - 1'b1;
        end
    end

    always_comb begin
        if (!r_item.incl[r_frame]) begin
            add = '0;
        end else if (r_item.translate) begin
            add = coc_pkg::SUM_W'(adj) + 1'b1;
        end else begin
            add = coc_pkg::SUM_W'(r_item.len) + 1'b1;
        end
        base  = restart ? '0 : coc_pkg::SUM_W'(r_run);
        sum   = base + add;
        sat   = (sum > coc_pkg::SUM_W'(coc_pkg::OFFSET_MAX));
        n_run = sat ? coc_pkg::OFFSET_MAX : sum[coc_pkg::OFFSET_BITS-1:0];
        shown = coc_pkg::SUM_W'(r_item.bad ? r_run : n_run);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_frame      <= '0;
            r_run        <= '0;
            r_fctx       <= coc_pkg::FCTX_NONE;
            o_out_valid  <= 1'b0;
        end else begin
            if (o_item_ready && i_item_valid) begin
                r_item_valid <= 1'b1;
                r_frame      <= '0;
            end else if (emit && is_last) begin
                r_item_valid <= 1'b0;
            end else if (emit) begin
                r_frame <= r_frame + 1'b1;
            end
            if (emit && !r_item.bad) begin
                r_run <= n_run;
                if (restart) begin
                    r_fctx <= r_item.fctx;
                end
            end
            if (out_ready) begin
                o_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_ready && i_item_valid) begin
            r_item <= i_item;
        end
        if (emit) begin
            o_frame_index    <= r_frame;
            o_context_offset <= shown[coc_pkg::OUT_OFF_W-1:0];
            o_first_context  <= (restart && !r_item.bad) ? r_item.fctx : r_fctx;
            o_overflow       <= sat && !r_item.bad;
            o_bad_input      <= r_item.bad;
            o_last           <= is_last;
        end
    end

endmodule

FILE: hw/rtl/context_offset_calculator_core.sv
// ----------------------------------------------------------------------------
// context_offset_calculator_core: query passes input, item and output registers
// Throughput: one result per cycle unless the output stalls; a query gives one
// result (protein or bad input), two (nucleotide) or six (translated frames).
// Reset (synchronous, active low): offset and first context zero, protein, both.
// ----------------------------------------------------------------------------
`include "context_offset_calculator_core_assert.svh"

module context_offset_calculator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Query input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [coc_pkg::LEN_W-1:0]       i_query_length,
    input  logic [2:0]                      i_query_strand,
    input  logic                            i_first_query,
    // Result output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [coc_pkg::FRAME_W-1:0]     o_frame_index,
    output logic [coc_pkg::OUT_OFF_W-1:0]   o_context_offset,
    output logic [1:0]                      o_first_context,
    output logic                            o_overflow,
    output logic                            o_bad_input,
    output logic                            o_last,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [2:0]                      i_cfg_data
);

    // Configuration registers
    logic [2:0]                     r_program_mode;
    logic [1:0]                     r_strand_option;

    // Input register: holds one query while the frame stage is busy
    logic                           r_in_valid;
    logic [coc_pkg::LEN_W-1:0]      r_in_length;
    logic [2:0]                     r_in_strand;
    logic                           r_in_first;

    coc_pkg::t_item                 dec_item;
    logic                           item_ready;

    // Writes are always taken; the user is to change configuration only while idle; the block does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_program_mode  <= coc_pkg::MODE_PROT;
            r_strand_option <= coc_pkg::STRAND_BOTH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                coc_pkg::CFG_PROGRAM_MODE:  r_program_mode  <= i_cfg_data;
                coc_pkg::CFG_STRAND_OPTION: r_strand_option <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Stall the input only when the held query cannot advance this cycle
    assign o_in_stall = r_in_valid && !item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload: load on every transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_length <= i_query_length;
            r_in_strand <= i_query_strand;
            r_in_first  <= i_first_query;
        end
    end

    // Decode: strand resolution, bad-input check and the divide by three
    coc_decode u_decode (
        .i_program_mode  (r_program_mode),
        .i_strand_option (r_strand_option),
        .i_query_length  (r_in_length),
        .i_query_strand  (r_in_strand),
        .i_first_query   (r_in_first),
        .o_item          (dec_item)
    );

    // Frame stage: one result per cycle, unless the output stalls, into the output register
    coc_frame u_frame (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (r_in_valid),
        .i_item           (dec_item),
        .o_item_ready     (item_ready),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_index    (o_frame_index),
        .o_context_offset (o_context_offset),
        .o_first_context  (o_first_context),
        .o_overflow       (o_overflow),
        .o_bad_input      (o_bad_input),
        .o_last           (o_last)
    );

    // A bad query gives a single closing result with no saturation
    `COC_ASSERT_NOW(a_bad_single, o_out_valid && o_bad_input,
        o_last && !o_overflow && (o_frame_index == '0))
    // Frame numbers stay within the six frames of a translated query
    `COC_ASSERT_NOW(a_frame_range, o_out_valid,
        o_frame_index < coc_pkg::FRAME_W'(coc_pkg::NUM_FRAMES))
    // A held query is not dropped while the frame stage is busy
    `COC_ASSERT_NEXT(a_in_hold, r_in_valid && o_in_stall, r_in_valid)

endmodule
